@@ rtl/modexp_pkg.sv @@
// Shared constants for the modular exponentiation block.
package modexp_pkg;

  // Width of the scanned multiplier operand (base, running result, power)
  localparam int unsigned OPERAND_W = 32;
  // Step counter width for one bit-serial multiplication
  localparam int unsigned STEP_W    = $clog2(OPERAND_W);

  // Configuration port
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 8'd1;

  // Register reset values
  localparam logic [31:0] EXPONENT_RST = 32'd17;
  localparam logic [31:0] MODULUS_RST  = 32'd3233;

endpackage

@@ rtl/modexp_mulmod.sv @@
// Bit-serial interleaved modular multiplier: result = x * y mod m, one bit of x a cycle.
module modexp_mulmod #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [modexp_pkg::OPERAND_W-1:0]     x,
  input  logic [MOD_WIDTH-1:0]                 y,
  input  logic [MOD_WIDTH-1:0]                 m,
  output logic                                 done,
  output logic [MOD_WIDTH-1:0]                 result
);

  // Partial sum 2*acc + y stays below 3*m
  localparam int unsigned TW = MOD_WIDTH + 2;
  localparam int unsigned XW = modexp_pkg::OPERAND_W;
  localparam int unsigned SW = modexp_pkg::STEP_W;
  localparam logic [SW-1:0] LAST_STEP = SW'(XW - 1);

  logic [XW-1:0]        x_sh_r, x_sh_nxt;
  logic [MOD_WIDTH-1:0] y_r, y_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [SW-1:0]        step_r, step_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;

  logic [TW-1:0] sum;
  logic [TW-1:0] m1;
  logic [TW-1:0] m2;
  logic [TW-1:0] red;

  // One step: double, add y when the scanned bit is set, fold back below m
  always_comb begin
    m1  = TW'(m);
    m2  = TW'({m, 1'b0});
    sum = TW'({acc_r, 1'b0}) + (x_sh_r[XW-1] ? TW'(y_r) : '0);
    if (sum >= m2) begin
      red = sum - m2;
    end else if (sum >= m1) begin
      red = sum - m1;
    end else begin
      red = sum;
    end
  end

  // Sequencing of the 32 steps
  always_comb begin
    x_sh_nxt = x_sh_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      x_sh_nxt = x;
      y_nxt    = y;
      acc_nxt  = '0;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      x_sh_nxt = {x_sh_r[XW-2:0], 1'b0};
      acc_nxt  = red[MOD_WIDTH-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_sh_r <= x_sh_nxt;
    y_r    <= y_nxt;
    acc_r  <= acc_nxt;
  end

  assign done   = done_r;
  assign result = acc_r;

endmodule

@@ rtl/modular_exponentiation_top.sv @@
// Top level of the modular exponentiation block: handshake, key registers and sequencer.
//
// Each base transfer returns one result: base^exponent mod modulus, computed by
// right-to-left square-and-multiply with two bit-serial modular multipliers that
// work one bit per cycle. The base is first reduced, then every exponent bit up
// to the highest set one takes one multiply and one square, the multiply and the
// square running side by side. The next base can be taken as soon as the result
// is valid; a zero modulus skips the multipliers and returns 0 with modulus_error
// set. One item is in work at a time; a finished result waits in the output
// register while the next base is accepted. The user must write exponent and
// modulus on the cfg port (index 0 and 1) only while the block is idle; the block
// itself does not enforce this. Only the low MOD_WIDTH bits of the modulus are kept.
module modular_exponentiation_top #(
  parameter int unsigned MOD_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // base input
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [31:0]                           in_base_value,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [31:0]                           out_power_result,
  output logic                                  out_modulus_error,
  // configuration writes
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [modexp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                           cfg_data
);

  localparam int unsigned XW = modexp_pkg::OPERAND_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_LSTART = 3'd2;
  localparam logic [2:0] S_LOOP   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [31:0]          exponent_r, exponent_nxt;
  logic [MOD_WIDTH-1:0] modulus_r, modulus_nxt;

  logic [2:0]           state_r, state_nxt;
  logic [31:0]          bits_r, bits_nxt;
  logic [MOD_WIDTH-1:0] acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0] power_r, power_nxt;
  logic                 err_r, err_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [31:0]          out_res_r, out_res_nxt;
  logic                 out_err_r, out_err_nxt;

  logic                 in_xfer;
  logic                 out_free;

  // multiplier A: base reduction, then acc * power
  logic                 a_start;
  logic [XW-1:0]        a_x;
  logic [MOD_WIDTH-1:0] a_y;
  logic                 a_done;
  logic [MOD_WIDTH-1:0] a_res;
  // multiplier B: power * power
  logic                 b_start;
  logic                 b_done;
  logic [MOD_WIDTH-1:0] b_res;

  logic [MOD_WIDTH-1:0] one_mod;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // 1 mod m: zero when the modulus is one
  assign one_mod = (modulus_r == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);

  // Key register writes
  always_comb begin
    exponent_nxt = exponent_r;
    modulus_nxt  = modulus_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == modexp_pkg::REG_EXPONENT) begin
        exponent_nxt = cfg_data;
      end else if (cfg_index == modexp_pkg::REG_MODULUS) begin
        modulus_nxt = cfg_data[MOD_WIDTH-1:0];
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    bits_nxt      = bits_r;
    acc_nxt       = acc_r;
    power_nxt     = power_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_err_nxt   = out_err_r;
    a_start       = 1'b0;
    b_start       = 1'b0;
    a_x           = 32'(acc_r);
    a_y           = power_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          bits_nxt = exponent_r;
          if (modulus_r == '0) begin
            acc_nxt   = '0;
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            acc_nxt   = MOD_WIDTH'(1);
            err_nxt   = 1'b0;
            a_start   = 1'b1;
            a_x       = in_base_value;
            a_y       = one_mod;
            state_nxt = S_REDUCE;
          end
        end
      end
      S_REDUCE: begin
        if (a_done) begin
          power_nxt = a_res;
          state_nxt = S_LSTART;
        end
      end
      S_LSTART: begin
        if (bits_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          a_start   = 1'b1;
          b_start   = 1'b1;
          state_nxt = S_LOOP;
        end
      end
      S_LOOP: begin
        // both units finish in the same cycle
        if (a_done && b_done) begin
          if (bits_r[0]) begin
            acc_nxt = a_res;
          end
          power_nxt = b_res;
          bits_nxt  = {1'b0, bits_r[31:1]};
          state_nxt = S_LSTART;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = 32'(acc_r);
          out_err_nxt   = err_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exponent_r  <= modexp_pkg::EXPONENT_RST;
      modulus_r   <= MOD_WIDTH'(modexp_pkg::MODULUS_RST);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      exponent_r  <= exponent_nxt;
      modulus_r   <= modulus_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r    <= bits_nxt;
    acc_r     <= acc_nxt;
    power_r   <= power_nxt;
    err_r     <= err_nxt;
    out_res_r <= out_res_nxt;
    out_err_r <= out_err_nxt;
  end

  modexp_mulmod #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mul_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (a_start),
    .x      (a_x),
    .y      (a_y),
    .m      (modulus_r),
    .done   (a_done),
    .result (a_res)
  );

  modexp_mulmod #(
    .MOD_WIDTH (MOD_WIDTH)
  ) u_mul_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (b_start),
    .x      (32'(power_r)),
    .y      (power_r),
    .m      (modulus_r),
    .done   (b_done),
    .result (b_res)
  );

  assign out_valid         = out_valid_r;
  assign out_power_result  = out_res_r;
  assign out_modulus_error = out_err_r;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for modular_exponentiation_top: directed keys, then random traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MOD_WIDTH    = 32;
  localparam logic [31:0] MOD_KEEP     = 32'((64'd1 << MOD_WIDTH) - 64'd1);
  localparam int          ITEM_TARGET  = 290;
  localparam int          LIMIT_CYCLES = 2_000_000;
  localparam int          TAIL_CYCLES  = 50;
  // Indexes past the register list; writes there must be dropped
  localparam logic [modexp_pkg::CFG_IDX_W-1:0] REG_FIRST_UNUSED =
    modexp_pkg::REG_MODULUS + 1'b1;
  localparam logic [modexp_pkg::CFG_IDX_W-1:0] REG_LAST_UNUSED  = '1;

  typedef struct packed {
    logic [31:0] power_result;
    logic        modulus_error;
  } modexp_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [31:0]          in_base_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [31:0]          out_power_result;
  logic                 out_modulus_error;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [modexp_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  // Key registers as the block should hold them
  logic [31:0]          key_exponent = modexp_pkg::EXPONENT_RST;
  logic [31:0]          key_modulus  = modexp_pkg::MODULUS_RST & MOD_KEEP;

  modexp_result_t       awaited_powers[$];
  int                   fail_count = 0;
  int                   items_sent = 0;
  int                   results_seen = 0;
  int                   error_results = 0;
  int                   cfg_writes = 0;
  int                   cycle_count = 0;
  int                   rx_hold = 0;
  bit                   quiet_mode = 1'b0;

  modular_exponentiation_top #(.MOD_WIDTH(MOD_WIDTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_base_value     (in_base_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_power_result  (out_power_result),
    .out_modulus_error (out_modulus_error),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Right-to-left square-and-multiply on the current key
  function automatic modexp_result_t predict_power(input logic [31:0] base_value);
    modexp_result_t r;
    logic [63:0]    m;
    logic [63:0]    sq;
    logic [63:0]    acc;
    logic [31:0]    bits;
    r.power_result  = '0;
    r.modulus_error = 1'b0;
    if (key_modulus == '0) begin
      r.modulus_error = 1'b1;
      return r;
    end
    m    = {32'd0, key_modulus};
    sq   = {32'd0, base_value} % m;
    acc  = 64'd1;
    bits = key_exponent;
    while (bits != '0) begin
      if (bits[0]) begin
        acc = (acc * sq) % m;
      end
      sq   = (sq * sq) % m;
      bits = bits >> 1;
    end
    r.power_result = acc[31:0];
    return r;
  endfunction

  function automatic int idle_draw();
    return quiet_mode ? 0 : $urandom_range(0, 12);
  endfunction

  // One base transfer; valid stays high afterwards so the next item can follow directly
  task automatic send_base(input logic [31:0] base_value);
    int gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_base_value <= base_value;
    do @(posedge clk); while (!in_ready);
    awaited_powers.push_back(predict_power(base_value));
    items_sent++;
  endtask

  // Stop sending and wait until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    while (awaited_powers.size() != 0) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [modexp_pkg::CFG_IDX_W-1:0] index,
                               input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      modexp_pkg::REG_EXPONENT: key_exponent = data;
      modexp_pkg::REG_MODULUS:  key_modulus  = data & MOD_KEEP;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic apply_key(input logic [31:0] exponent_value, input logic [31:0] modulus_value);
    drain_results();
    write_key_reg(modexp_pkg::REG_EXPONENT, exponent_value);
    write_key_reg(modexp_pkg::REG_MODULUS, modulus_value);
    cfg_valid <= 1'b0;
  endtask

  // Result side: random stall per result, then compare against the oldest prediction
  always @(posedge clk) begin : result_check
    modexp_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold = idle_draw();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_modulus_error) error_results++;
        if (awaited_powers.size() == 0) begin
          $display("%0t: unexpected result transfer: power_result %h modulus_error %b",
                   $time, out_power_result, out_modulus_error);
          fail_count++;
        end else begin
          want = awaited_powers.pop_front();
          if (out_power_result !== want.power_result) begin
            $display("%0t: power_result mismatch: expected %h, actual %h",
                     $time, want.power_result, out_power_result);
            fail_count++;
          end
          if (out_modulus_error !== want.modulus_error) begin
            $display("%0t: modulus_error mismatch: expected %b, actual %b",
                     $time, want.modulus_error, out_modulus_error);
            fail_count++;
          end
        end
        rx_hold = idle_draw();
      end else if (out_valid && rx_hold != 0) begin
        rx_hold--;
      end
      out_ready <= (rx_hold == 0);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("TB_ERROR");
    $finish;
  end

  // Reset key: textbook RSA pair plus base extremes
  task automatic test_reset_key();
    send_base(32'd0);
    send_base(32'd1);
    send_base(32'd65);
    send_base(32'd3232);
    send_base(32'd3233);
    send_base(32'hFFFF_FFFF);
    send_base(32'h8000_0000);
  endtask

  // Zero exponent, zero modulus and unit modulus corners
  task automatic test_degenerate_keys();
    apply_key(32'd0, 32'd1);
    send_base(32'd5);
    apply_key(32'd0, 32'd0);
    send_base(32'd7);
    apply_key(32'd17, 32'd0);
    send_base(32'hFFFF_FFFF);
    apply_key(32'd5, 32'd1);
    send_base(32'd12345);
    apply_key(32'd1, 32'd2);
    send_base(32'd3);
  endtask

  // Full-width exponent and modulus
  task automatic test_wide_keys();
    apply_key(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_base(32'hFFFF_FFFE);
    send_base(32'hFFFF_FFFF);
    send_base(32'd2);
    apply_key(32'h8000_0001, 32'h8000_0000);
    send_base(32'd3);
    send_base(32'hFFFF_FFFF);
  endtask

  // Writes past the register list must leave the key alone
  task automatic test_ignored_index();
    apply_key(32'd3, 32'd1000);
    write_key_reg(REG_FIRST_UNUSED, 32'd0);
    write_key_reg(REG_LAST_UNUSED, 32'd0);
    cfg_valid <= 1'b0;
    send_base(32'd7);
  endtask

  // Sender holds off mid-stream until everything outstanding has returned
  task automatic test_drain_pause();
    apply_key(32'd65537, 32'd3233);
    repeat (3) send_base($urandom);
    drain_results();
    repeat (3) send_base($urandom);
  endtask

  function automatic logic [31:0] draw_exponent();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 40);
      2:       return 32'd1 << $urandom_range(0, 31);
      3:       return 32'hFFFF_FFFF;
      4:       return 32'd0;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic logic [31:0] draw_modulus();
    case ($urandom_range(0, 7))
      0, 1:    return $urandom;
      2:       return $urandom_range(1, 255);
      3:       return 32'd0;
      4:       return 32'd1;
      5:       return 32'hFFFF_FFFF;
      6:       return $urandom | 32'h8000_0000;
      default: return $urandom_range(2, 70000);
    endcase
  endfunction

  function automatic logic [31:0] draw_base();
    case ($urandom_range(0, 6))
      0, 1:    return $urandom;
      2:       return $urandom_range(0, 15);
      3:       return key_modulus + 32'($urandom_range(0, 2)) - 32'd1;
      4:       return 32'hFFFF_FFFF;
      5:       return key_modulus * 32'($urandom_range(0, 5));
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // Random key phases, each followed by a burst of bases
  task automatic test_random_traffic();
    int burst;
    int k;
    while (items_sent < ITEM_TARGET) begin
      drain_results();
      quiet_mode = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       write_key_reg(modexp_pkg::REG_EXPONENT, draw_exponent());
        1:       write_key_reg(modexp_pkg::REG_MODULUS, draw_modulus());
        default: begin
          write_key_reg(modexp_pkg::REG_EXPONENT, draw_exponent());
          write_key_reg(modexp_pkg::REG_MODULUS, draw_modulus());
        end
      endcase
      if ($urandom_range(0, 5) == 0) begin
        write_key_reg(modexp_pkg::CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED)),
                      $urandom);
      end
      cfg_valid <= 1'b0;
      burst = $urandom_range(4, 16);
      for (k = 0; k < burst; k++) begin
        if ($urandom_range(0, 24) == 0) drain_results();
        send_base(draw_base());
      end
    end
    quiet_mode = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_key();
    test_degenerate_keys();
    test_wide_keys();
    test_ignored_index();
    test_drain_pause();
    test_random_traffic();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d bases across %0d register writes in %0d cycles.",
             items_sent, cfg_writes, cycle_count);
    $display("Checked %0d results, %0d of them flagged as zero-modulus errors.",
             results_seen, error_results);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d failures", fail_count);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ modular_exponentiation_top.f @@
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation_top.sv
tb/testbench.sv
